>>> src/hptc_pkg.sv
// ----------------------------------------------------------------------------
// hptc_pkg
// Shared types and constants of the humidity/pressure/temperature block.
// ----------------------------------------------------------------------------
package hptc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP      = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_HI  = 3'd2,
    REG_PRESS_HUM = 3'd3,
    REG_HUM       = 3'd4
  } cfg_reg_e;

  // Divider word width: one quotient bit per pipeline stage
  localparam int unsigned DIV_W = 64;

  // Pipeline depth and side delay lines (stage numbers start at 1)
  localparam int unsigned STG_N    = 85;
  localparam int unsigned RP_DLY   = 10;  // raw pressure, stage 1..10
  localparam int unsigned RH_DLY   = 5;   // raw humidity, stage 1..5
  localparam int unsigned TEMP_DLY = 79;  // temperature, stage 6..84
  localparam int unsigned HUM_DLY  = 69;  // humidity, stage 16..84

  // Flags that ride along with an operand pair through the divider
  typedef struct packed {
    logic neg;
    logic zero;
  } div_side_t;

endpackage

>>> src/hptc_mul64.sv
// ----------------------------------------------------------------------------
// hptc_mul64
// Two-stage 64x64 multiplier, low 64 bits of the product (two's complement).
// ----------------------------------------------------------------------------
module hptc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_c, ll_q;
  logic [31:0] hl_c, hl_q;
  logic [31:0] lh_c, lh_q;
  logic [31:0] cross_c;
  logic [63:0] p_q;

  // Partial products; the high-by-high term drops out of the low word
  always_comb begin
    ll_c    = {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
    hl_c    = a_i[63:32] * b_i[31:0];
    lh_c    = a_i[31:0] * b_i[63:32];
    cross_c = hl_q + lh_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_c;
      hl_q <= hl_c;
      lh_q <= lh_c;
      p_q  <= ll_q + {cross_c, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

>>> src/hptc_div.sv
// ----------------------------------------------------------------------------
// hptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hptc_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [hptc_pkg::DIV_W-1:0]      num_i,
  input  logic [hptc_pkg::DIV_W-1:0]      den_i,
  input  hptc_pkg::div_side_t             side_i,
  output logic [hptc_pkg::DIV_W-1:0]      quo_o,
  output hptc_pkg::div_side_t             side_o
);

  logic [hptc_pkg::DIV_W-1:0] rem_q  [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] dvd_q  [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] den_q  [hptc_pkg::DIV_W];
  hptc_pkg::div_side_t        side_q [hptc_pkg::DIV_W];

  logic [hptc_pkg::DIV_W-1:0] rem_d   [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] dvd_d   [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] prem_c  [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] pdvd_c  [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W-1:0] pden_c  [hptc_pkg::DIV_W];
  hptc_pkg::div_side_t        pside_c [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W:0]   trial_c [hptc_pkg::DIV_W];
  logic [hptc_pkg::DIV_W:0]   diff_c  [hptc_pkg::DIV_W];

  always_comb begin
    for (int i = 0; i < hptc_pkg::DIV_W; i++) begin
      if (i == 0) begin
        prem_c[i]  = '0;
        pdvd_c[i]  = num_i;
        pden_c[i]  = den_i;
        pside_c[i] = side_i;
      end else begin
        prem_c[i]  = rem_q[i-1];
        pdvd_c[i]  = dvd_q[i-1];
        pden_c[i]  = den_q[i-1];
        pside_c[i] = side_q[i-1];
      end
      trial_c[i] = {prem_c[i], pdvd_c[i][hptc_pkg::DIV_W-1]};
      diff_c[i]  = trial_c[i] - {1'b0, pden_c[i]};
      if (!diff_c[i][hptc_pkg::DIV_W]) begin
        rem_d[i] = diff_c[i][hptc_pkg::DIV_W-1:0];
        dvd_d[i] = {pdvd_c[i][hptc_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d[i] = trial_c[i][hptc_pkg::DIV_W-1:0];
        dvd_d[i] = {pdvd_c[i][hptc_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < hptc_pkg::DIV_W; i++) begin
        rem_q[i]  <= rem_d[i];
        dvd_q[i]  <= dvd_d[i];
        den_q[i]  <= pden_c[i];
        side_q[i] <= pside_c[i];
      end
    end
  end

  assign quo_o  = dvd_q[hptc_pkg::DIV_W-1];
  assign side_o = side_q[hptc_pkg::DIV_W-1];

endmodule

>>> src/humidity_pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// humidity_pressure_temp_compensation_top
// Integer compensation of a raw pressure/temperature/humidity sample triple.
// ----------------------------------------------------------------------------
// One raw triple per transaction in, one compensated triple per transaction
// out, in order. The pipeline takes a new triple every cycle while the output
// side is not stalled and is 85 stages deep. The 64-stage pressure divider
// (one quotient bit per stage) makes up most of that depth. The 64-bit
// pressure products go through two-stage multipliers. When the output is
// held, the whole pipeline freezes in place and s_axis_tready drops; nothing
// is lost or repeated. Calibration words are written through the cfg port
// (index 0..4, others ignored) and must only change while no triple is in
// flight. A zero pressure divisor yields a pressure of 0. Humidity is clamped
// to 0..100 %RH before the last shift.
// ----------------------------------------------------------------------------
module humidity_pressure_temp_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Calibration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // Raw sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
  input  logic [55:0] s_axis_tdata,
  // Compensated result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] temperature, [63:32] pressure, [80:64] humidity, [87:81] zero
  output logic [87:0] m_axis_tdata
);

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [47:0] temp_coef_q;
  logic [63:0] press_lo_q;
  logic [63:0] press_hi_q;
  logic [47:0] press_hum_q;
  logic [39:0] hum_coef_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q <= '0;
      press_lo_q  <= '0;
      press_hi_q  <= '0;
      press_hum_q <= '0;
      hum_coef_q  <= '0;
    end else if (cfg_valid_i) begin
      case (hptc_pkg::cfg_reg_e'(cfg_index_i))
        hptc_pkg::REG_TEMP:      temp_coef_q <= cfg_data_i[47:0];
        hptc_pkg::REG_PRESS_LO:  press_lo_q  <= cfg_data_i;
        hptc_pkg::REG_PRESS_HI:  press_hi_q  <= cfg_data_i;
        hptc_pkg::REG_PRESS_HUM: press_hum_q <= cfg_data_i[47:0];
        hptc_pkg::REG_HUM:       hum_coef_q  <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // Unpacked coefficients, widened to the working word of their path
  logic [15:0]        t1;
  logic signed [31:0] t2_c, t3_c;
  logic signed [63:0] p1_c, p2_c, p3_c, p5_c, p6_c, p8_c, p9_c;
  logic [15:0]        p4, p7;
  logic signed [31:0] h1_c, h2_c, h3_c, h5_c, h6_c;
  logic [15:0]        h4;

  always_comb begin
    t1   = temp_coef_q[15:0];
    t2_c = {{16{temp_coef_q[31]}}, temp_coef_q[31:16]};
    t3_c = {{16{temp_coef_q[47]}}, temp_coef_q[47:32]};
    p1_c = {48'b0, press_lo_q[15:0]};
    p2_c = {{48{press_lo_q[31]}}, press_lo_q[31:16]};
    p3_c = {{48{press_lo_q[47]}}, press_lo_q[47:32]};
    p4   = press_lo_q[63:48];
    p5_c = {{48{press_hi_q[15]}}, press_hi_q[15:0]};
    p6_c = {{48{press_hi_q[31]}}, press_hi_q[31:16]};
    p7   = press_hi_q[47:32];
    p8_c = {{48{press_hi_q[63]}}, press_hi_q[63:48]};
    p9_c = {{48{press_hum_q[15]}}, press_hum_q[15:0]};
    h1_c = {24'b0, press_hum_q[23:16]};
    h2_c = {{16{press_hum_q[39]}}, press_hum_q[39:24]};
    h3_c = {24'b0, press_hum_q[47:40]};
    h4   = hum_coef_q[15:0];
    h5_c = {{16{hum_coef_q[31]}}, hum_coef_q[31:16]};
    h6_c = {{24{hum_coef_q[39]}}, hum_coef_q[39:32]};
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for every stage, valid bits shift along
  // --------------------------------------------------------------------------
  logic                      en;
  logic [hptc_pkg::STG_N:1]  vld_q;

  assign en            = !vld_q[hptc_pkg::STG_N] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[hptc_pkg::STG_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[hptc_pkg::STG_N-1:1], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Temperature, 32-bit wrap (stages 1..5)
  // --------------------------------------------------------------------------
  logic [19:0]        rt1_q;
  logic [19:0]        rp_dly_q [hptc_pkg::RP_DLY];
  logic [15:0]        rh_dly_q [hptc_pkg::RH_DLY];
  logic signed [31:0] a_c, b_c, at2_c, bb_c;
  logic signed [31:0] at2_2_q, bb2_q;
  logic signed [31:0] v1t_c, c_c, ct3_c;
  logic signed [31:0] v1t3_q, ct3_3_q;
  logic signed [31:0] v2t_c, tf_c, tf4_q;
  logic signed [31:0] t5x_c, temp_c, temp5_q;
  logic signed [63:0] v1p_c, v1p5_q;
  logic signed [31:0] vh_c, vh5_q;

  always_comb begin
    a_c    = $signed({15'b0, rt1_q[19:3]}) - $signed({15'b0, t1, 1'b0});
    b_c    = $signed({16'b0, rt1_q[19:4]}) - $signed({16'b0, t1});
    at2_c  = a_c * t2_c;
    bb_c   = b_c * b_c;
    v1t_c  = at2_2_q >>> 11;
    c_c    = bb2_q >>> 12;
    ct3_c  = c_c * t3_c;
    v2t_c  = ct3_3_q >>> 14;
    tf_c   = v1t3_q + v2t_c;
    // tf * 5 + 128
    t5x_c  = tf4_q + (tf4_q <<< 2) + 32'sd128;
    temp_c = t5x_c >>> 8;
    v1p_c  = {{32{tf4_q[31]}}, tf4_q} - 64'sd128000;
    vh_c   = tf4_q - 32'sd76800;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt1_q       <= s_axis_tdata[39:20];
      rp_dly_q[0] <= s_axis_tdata[19:0];
      rh_dly_q[0] <= s_axis_tdata[55:40];
      for (int i = 1; i < hptc_pkg::RP_DLY; i++) rp_dly_q[i] <= rp_dly_q[i-1];
      for (int i = 1; i < hptc_pkg::RH_DLY; i++) rh_dly_q[i] <= rh_dly_q[i-1];
      at2_2_q <= at2_c;
      bb2_q   <= bb_c;
      v1t3_q  <= v1t_c;
      ct3_3_q <= ct3_c;
      tf4_q   <= tf_c;
      temp5_q <= temp_c;
      v1p5_q  <= v1p_c;
      vh5_q   <= vh_c;
    end
  end

  // --------------------------------------------------------------------------
  // Humidity, 32-bit wrap (stages 6..15)
  // --------------------------------------------------------------------------
  logic signed [31:0] x0_c, hv5_c, pv6_c, pv3_c;
  logic signed [31:0] x0_6_q, hv5_6_q, pv6_6_q, pv3_6_q;
  logic signed [31:0] xs_c, x_c, y_c, z_c;
  logic signed [31:0] x7_q, y7_q, z7_q;
  logic signed [31:0] yz_c, x8_q, yz8_q;
  logic signed [31:0] yzs_c, y2_c, x9_q, y2_9_q;
  logic signed [31:0] yh_c, x10_q, yh10_q;
  logic signed [31:0] yhr_c, y3_c, x11_q, y3_11_q;
  logic signed [31:0] vv_c, vv12_q;
  logic signed [31:0] s15_c, q0_c, vv13_q, q0_13_q;
  logic signed [31:0] q_c, qh_c, vv14_q, qh14_q;
  logic signed [31:0] qs_c, hv_c, hcl_c;
  logic [16:0]        hum15_q;

  always_comb begin
    x0_c  = $signed({2'b0, rh_dly_q[hptc_pkg::RH_DLY-1], 14'b0}) - $signed({h4[11:0], 20'b0});
    hv5_c = h5_c * vh5_q;
    pv6_c = vh5_q * h6_c;
    pv3_c = vh5_q * h3_c;
    xs_c  = x0_6_q - hv5_6_q + 32'sd16384;
    x_c   = xs_c >>> 15;
    y_c   = pv6_6_q >>> 10;
    z_c   = pv3_6_q >>> 11;
    yz_c  = y7_q * (z7_q + 32'sd32768);
    yzs_c = yz8_q >>> 10;
    y2_c  = yzs_c + 32'sd2097152;
    yh_c  = y2_9_q * h2_c;
    yhr_c = yh10_q + 32'sd8192;
    y3_c  = yhr_c >>> 14;
    vv_c  = x11_q * y3_11_q;
    s15_c = vv12_q >>> 15;
    q0_c  = s15_c * s15_c;
    q_c   = q0_13_q >>> 7;
    qh_c  = q_c * h1_c;
    qs_c  = qh14_q >>> 4;
    hv_c  = vv14_q - qs_c;
    // clamp to 0..100 %RH in Q10.22 before the final >> 12
    if (hv_c < 32'sd0) begin
      hcl_c = 32'sd0;
    end else if (hv_c > 32'sd419430400) begin
      hcl_c = 32'sd419430400;
    end else begin
      hcl_c = hv_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_6_q  <= x0_c;
      hv5_6_q <= hv5_c;
      pv6_6_q <= pv6_c;
      pv3_6_q <= pv3_c;
      x7_q    <= x_c;
      y7_q    <= y_c;
      z7_q    <= z_c;
      x8_q    <= x7_q;
      yz8_q   <= yz_c;
      x9_q    <= x8_q;
      y2_9_q  <= y2_c;
      x10_q   <= x9_q;
      yh10_q  <= yh_c;
      x11_q   <= x10_q;
      y3_11_q <= y3_c;
      vv12_q  <= vv_c;
      vv13_q  <= vv12_q;
      q0_13_q <= q0_c;
      vv14_q  <= vv13_q;
      qh14_q  <= qh_c;
      hum15_q <= hcl_c[28:12];
    end
  end

  // --------------------------------------------------------------------------
  // Pressure, 64-bit wrap
  // --------------------------------------------------------------------------
  // stage 7: v1*v1, v1*P5, v1*P2
  logic [63:0] vv7, m5_7, m2_7;
  hptc_mul64 u_mul_vv (.clk_i, .en_i(en), .a_i(v1p5_q), .b_i(v1p5_q), .p_o(vv7));
  hptc_mul64 u_mul_p5 (.clk_i, .en_i(en), .a_i(v1p5_q), .b_i(p5_c),   .p_o(m5_7));
  hptc_mul64 u_mul_p2 (.clk_i, .en_i(en), .a_i(v1p5_q), .b_i(p2_c),   .p_o(m2_7));

  // stage 9: v1^2*P6, v1^2*P3
  logic [63:0]        v2a9, v1a9;
  logic [63:0]        m5_8_q, m5_9_q, m2_8_q, m2_9_q;
  hptc_mul64 u_mul_p6 (.clk_i, .en_i(en), .a_i(vv7), .b_i(p6_c), .p_o(v2a9));
  hptc_mul64 u_mul_p3 (.clk_i, .en_i(en), .a_i(vv7), .b_i(p3_c), .p_o(v1a9));

  // stage 10: var2 and (2^47 + var1) sums
  logic signed [63:0] v1as_c, v2_c, s_c;
  logic signed [63:0] v2_10_q, s10_q;
  // stage 11: (1048576 - adc) << 31, minus var2
  logic [20:0]        pp_c;
  logic signed [63:0] pd_c, pd11_q;
  logic [63:0]        dprod12, num13;
  logic signed [63:0] dsh_c, d13_q;

  always_comb begin
    v1as_c = $signed(v1a9) >>> 8;
    v2_c   = $signed(v2a9) + $signed({m5_9_q[46:0], 17'b0})
           + $signed({{13{p4[15]}}, p4, 35'b0});
    s_c    = v1as_c + $signed({m2_9_q[51:0], 12'b0}) + 64'sh0000_8000_0000_0000;
    pp_c   = 21'd1048576 - {1'b0, rp_dly_q[hptc_pkg::RP_DLY-1]};
    pd_c   = $signed({12'b0, pp_c, 31'b0}) - v2_10_q;
    dsh_c  = $signed(dprod12) >>> 33;
  end

  // stage 12: divisor product; stage 13: numerator * 3125
  hptc_mul64 u_mul_p1  (.clk_i, .en_i(en), .a_i(s10_q),  .b_i(p1_c),   .p_o(dprod12));
  hptc_mul64 u_mul_num (.clk_i, .en_i(en), .a_i(pd11_q), .b_i(64'd3125), .p_o(num13));

  // stage 14: sign split for the unsigned divider
  logic [63:0]         an_c, ad_c, an14_q, ad14_q;
  hptc_pkg::div_side_t side_c, side14_q, side78;
  logic [63:0]         quo78;

  always_comb begin
    an_c        = num13[63] ? (~num13 + 64'd1) : num13;
    ad_c        = d13_q[63] ? (~d13_q + 64'sd1) : d13_q;
    side_c.neg  = num13[63] ^ d13_q[63];
    side_c.zero = (d13_q == 64'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m5_8_q   <= m5_7;
      m5_9_q   <= m5_8_q;
      m2_8_q   <= m2_7;
      m2_9_q   <= m2_8_q;
      v2_10_q  <= v2_c;
      s10_q    <= s_c;
      pd11_q   <= pd_c;
      d13_q    <= dsh_c;
      an14_q   <= an_c;
      ad14_q   <= ad_c;
      side14_q <= side_c;
    end
  end

  // stages 15..78: truncating quotient magnitude
  hptc_div u_div (
    .clk_i,
    .en_i   (en),
    .num_i  (an14_q),
    .den_i  (ad14_q),
    .side_i (side14_q),
    .quo_o  (quo78),
    .side_o (side78)
  );

  // stage 79: signed quotient p
  logic signed [63:0] p79_q, p80_q, p81_q, p82_q, p83_q;
  logic               zr79_q, zr80_q, zr81_q, zr82_q, zr83_q, zr84_q;
  logic signed [63:0] p13a_c, p13b_c;
  logic [63:0]        m9_81, m8_81, m99_83;
  logic signed [63:0] v2p_c, v2p82_q, v2p83_q;
  logic signed [63:0] v1x_c, t_c, t84_q;

  always_comb begin
    p13a_c = p79_q >>> 13;
    p13b_c = p81_q >>> 13;
    v2p_c  = $signed(m8_81) >>> 19;
    v1x_c  = $signed(m99_83) >>> 25;
    t_c    = p83_q + v1x_c + v2p83_q;
  end

  // stage 81: P9*(p>>13), P8*p; stage 83: times (p>>13) again
  hptc_mul64 u_mul_p9  (.clk_i, .en_i(en), .a_i(p13a_c), .b_i(p9_c),   .p_o(m9_81));
  hptc_mul64 u_mul_p8  (.clk_i, .en_i(en), .a_i(p79_q),  .b_i(p8_c),   .p_o(m8_81));
  hptc_mul64 u_mul_p99 (.clk_i, .en_i(en), .a_i(m9_81),  .b_i(p13b_c), .p_o(m99_83));

  always_ff @(posedge clk_i) begin
    if (en) begin
      p79_q   <= side78.neg ? $signed(~quo78 + 64'd1) : $signed(quo78);
      zr79_q  <= side78.zero;
      p80_q   <= p79_q;
      p81_q   <= p80_q;
      p82_q   <= p81_q;
      p83_q   <= p82_q;
      zr80_q  <= zr79_q;
      zr81_q  <= zr80_q;
      zr82_q  <= zr81_q;
      zr83_q  <= zr82_q;
      zr84_q  <= zr83_q;
      v2p82_q <= v2p_c;
      v2p83_q <= v2p82_q;
      t84_q   <= t_c;
    end
  end

  // --------------------------------------------------------------------------
  // Alignment of temperature/humidity, stage 85 output register
  // --------------------------------------------------------------------------
  logic signed [31:0] temp_dly_q [hptc_pkg::TEMP_DLY];
  logic [16:0]        hum_dly_q  [hptc_pkg::HUM_DLY];
  logic signed [63:0] tsh_c;
  logic [31:0]        press_c;
  logic [31:0]        temp_out_q, press_out_q;
  logic [16:0]        hum_out_q;

  always_comb begin
    tsh_c = t84_q >>> 8;
    if (zr84_q) begin
      press_c = '0;
    end else begin
      press_c = tsh_c[31:0] + {{12{p7[15]}}, p7, 4'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_dly_q[0] <= temp5_q;
      hum_dly_q[0]  <= hum15_q;
      for (int i = 1; i < hptc_pkg::TEMP_DLY; i++) temp_dly_q[i] <= temp_dly_q[i-1];
      for (int i = 1; i < hptc_pkg::HUM_DLY; i++) hum_dly_q[i] <= hum_dly_q[i-1];
      temp_out_q  <= temp_dly_q[hptc_pkg::TEMP_DLY-1];
      hum_out_q   <= hum_dly_q[hptc_pkg::HUM_DLY-1];
      press_out_q <= press_c;
    end
  end

  assign m_axis_tdata = {7'b0, hum_out_q, press_out_q, temp_out_q};

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the integer sample compensation block against a local predictor.
// ----------------------------------------------------------------------------
// Short directed table first: extreme raw triples under the reset calibration
// (all results zero, divisor zero), then the same triples under a typical
// calibration. After that come randomized phases, each with its own
// calibration: all-ones, all-zeros, random words and typical sets, one with
// random humidity terms. Calibration is written only once the pipeline has
// drained. Both stream sides idle at random; results are checked per field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_HALF   = 2;
  localparam int unsigned DRAIN_WAIT = 100;   // a bit more than the pipeline depth
  localparam int unsigned WDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned N_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS = 325;
  localparam int unsigned N_ZERO_ROWS = 6;    // rows checked with typed values

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
  } comp_res_t;

  typedef struct {
    logic [19:0] rp;
    logic [19:0] rt;
    logic [15:0] rh;
    comp_res_t   exp_res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;

  // calibration shadow, masked to the register widths
  logic [63:0] calib [5];
  comp_res_t   pending_res [$];
  int          err_cnt;
  bit          no_idle;     // stretches with no idling on either side
  int unsigned stall_left;
  int unsigned wdog_cnt;

  humidity_pressure_temp_compensation_top u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Directed triples. First N_ZERO_ROWS run under the reset calibration, where
  // every coefficient is zero: temperature and humidity collapse to zero and
  // the pressure divisor is zero, so the expected triple is all zeros.
  stim_row_t dir_rows [12] = '{
    '{20'd0,       20'd0,       16'd0,      '0},
    '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   '0},
    '{20'd0,       20'hFFFFF,   16'd0,      '0},
    '{20'hFFFFF,   20'd0,       16'hFFFF,   '0},
    '{20'd524288,  20'd519888,  16'd32768,  '0},
    '{20'd415148,  20'd519888,  16'd30000,  '0},
    // typical calibration from here on: predicted
    '{20'd0,       20'd0,       16'd0,      '0},
    '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   '0},
    '{20'd0,       20'hFFFFF,   16'd0,      '0},
    '{20'hFFFFF,   20'd0,       16'hFFFF,   '0},
    '{20'd524288,  20'd519888,  16'd32768,  '0},
    '{20'd415148,  20'd519888,  16'd30000,  '0}
  };

  // Compensation of one raw triple with the current calibration.
  function automatic comp_res_t compensate(logic [19:0] rp, logic [19:0] rt,
                                           logic [15:0] rh);
    int     t1, t2, t3, h1, h2, h3, h4, h5, h6, rti, rhi;
    int     a, b, c, w1, w2, tf, temp, v, x, y, z, q;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint e1, e2, pv, num, press;
    comp_res_t r;
    t1 = calib[hptc_pkg::REG_TEMP][15:0];
    t2 = $signed(calib[hptc_pkg::REG_TEMP][31:16]);
    t3 = $signed(calib[hptc_pkg::REG_TEMP][47:32]);
    p1 = calib[hptc_pkg::REG_PRESS_LO][15:0];
    p2 = $signed(calib[hptc_pkg::REG_PRESS_LO][31:16]);
    p3 = $signed(calib[hptc_pkg::REG_PRESS_LO][47:32]);
    p4 = $signed(calib[hptc_pkg::REG_PRESS_LO][63:48]);
    p5 = $signed(calib[hptc_pkg::REG_PRESS_HI][15:0]);
    p6 = $signed(calib[hptc_pkg::REG_PRESS_HI][31:16]);
    p7 = $signed(calib[hptc_pkg::REG_PRESS_HI][47:32]);
    p8 = $signed(calib[hptc_pkg::REG_PRESS_HI][63:48]);
    p9 = $signed(calib[hptc_pkg::REG_PRESS_HUM][15:0]);
    h1 = calib[hptc_pkg::REG_PRESS_HUM][23:16];
    h2 = $signed(calib[hptc_pkg::REG_PRESS_HUM][39:24]);
    h3 = calib[hptc_pkg::REG_PRESS_HUM][47:40];
    h4 = $signed(calib[hptc_pkg::REG_HUM][15:0]);
    h5 = $signed(calib[hptc_pkg::REG_HUM][31:16]);
    h6 = $signed(calib[hptc_pkg::REG_HUM][39:32]);
    rti = rt;
    rhi = rh;

    // temperature, wraps at 32 bits
    a    = (rti >>> 3) - (t1 <<< 1);
    w1   = (a * t2) >>> 11;
    b    = (rti >>> 4) - t1;
    c    = (b * b) >>> 12;
    w2   = (c * t3) >>> 14;
    tf   = w1 + w2;
    temp = (tf * 5 + 128) >>> 8;

    // pressure, wraps at 64 bits
    e1 = longint'(tf) - 64'sd128000;
    e2 = e1 * e1 * p6;
    e2 = e2 + ((e1 * p5) <<< 17);
    e2 = e2 + (p4 <<< 35);
    e1 = ((e1 * e1 * p3) >>> 8) + ((e1 * p2) <<< 12);
    e1 = (((64'sd1 <<< 47) + e1) * p1) >>> 33;
    if (e1 == 0) begin
      press = 0;
    end else begin
      pv  = 64'sd1048576 - longint'(rp);
      num = ((pv <<< 31) - e2) * 64'sd3125;
      // minus one handled apart: most negative over -1 wraps
      if (e1 == -64'sd1) pv = -num;
      else pv = num / e1;
      e1 = (p9 * (pv >>> 13) * (pv >>> 13)) >>> 25;
      e2 = (p8 * pv) >>> 19;
      press = ((pv + e1 + e2) >>> 8) + (p7 <<< 4);
    end

    // humidity, wraps at 32 bits, clamped before the last shift
    v = tf - 76800;
    x = (rhi <<< 14) - (h4 <<< 20) - (h5 * v);
    x = (x + 16384) >>> 15;
    y = (v * h6) >>> 10;
    z = ((v * h3) >>> 11) + 32768;
    y = ((y * z) >>> 10) + 2097152;
    y = (y * h2 + 8192) >>> 14;
    v = x * y;
    q = ((v >>> 15) * (v >>> 15)) >>> 7;
    v = v - ((q * h1) >>> 4);
    if (v < 0) v = 0;
    if (v > 419430400) v = 419430400;

    r.temp  = temp;
    r.press = press[31:0];
    r.hum   = v[28:12];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hptc_pkg::REG_TEMP:      calib[idx] = val & 64'hFFFF_FFFF_FFFF;
      hptc_pkg::REG_PRESS_LO:  calib[idx] = val;
      hptc_pkg::REG_PRESS_HI:  calib[idx] = val;
      hptc_pkg::REG_PRESS_HUM: calib[idx] = val & 64'hFFFF_FFFF_FFFF;
      hptc_pkg::REG_HUM:       calib[idx] = val & 64'hFF_FFFF_FFFF;
      default: ;     // out of range: ignored
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_calib(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                             logic [63:0] w3, logic [63:0] w4);
    write_reg(hptc_pkg::REG_TEMP, w0);
    write_reg(hptc_pkg::REG_PRESS_LO, w1);
    write_reg(hptc_pkg::REG_PRESS_HI, w2);
    write_reg(hptc_pkg::REG_PRESS_HUM, w3);
    write_reg(hptc_pkg::REG_HUM, w4);
    // index past the last register must leave everything alone
    write_reg(3'($urandom_range(7, 5)), {$urandom, $urandom});
  endtask

  // typical coefficient set of a real part
  task automatic write_typical();
    write_calib({16'hFC18, 16'd26435, 16'd27504},
                {16'd2855, 16'd3024, 16'hD443, 16'd36477},
                {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                {8'd0, 16'd370, 8'd75, 16'd6000},
                {8'd30, 16'd50, 16'd313});
  endtask

  // sender pause: nothing in flight before calibration changes
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  // one raw triple transaction; pushes the prediction at acceptance
  task automatic send_triple(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh,
                             bit use_typed, comp_res_t typed);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {rh, rt, rp};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_res.push_back(use_typed ? typed : compensate(rp, rt, rh));
  endtask

  // output side: random stalls, sampled by the checker at the rising edge
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else begin
      stall_left    = pick_gap();
      m_axis_tready = (stall_left == 0);
    end
  end

  initial begin
    no_idle = 1'b0;
    forever begin
      repeat ($urandom_range(400, 100)) @(posedge clk_i);
      no_idle = ($urandom_range(3) == 0);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    comp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_res.pop_front();
        if (m_axis_tdata[31:0] !== want.temp)
          report_mismatch("temperature", m_axis_tdata[31:0], want.temp);
        if (m_axis_tdata[63:32] !== want.press)
          report_mismatch("pressure", m_axis_tdata[63:32], want.press);
        if (m_axis_tdata[80:64] !== want.hum)
          report_mismatch("humidity", m_axis_tdata[80:64], want.hum);
        if (m_axis_tdata[87:81] !== '0)
          report_mismatch("pad bits", m_axis_tdata[87:81], '0);
      end
    end
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      wdog_cnt = 0;
    end else begin
      wdog_cnt++;
      if (wdog_cnt >= WDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] rp, rt;
    logic [15:0] rh;
    err_cnt       = 0;
    stall_left    = 0;
    wdog_cnt      = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    foreach (calib[i]) calib[i] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (i == N_ZERO_ROWS) begin
        drain();
        write_typical();
      end
      send_triple(dir_rows[i].rp, dir_rows[i].rt, dir_rows[i].rh,
                  i < N_ZERO_ROWS, dir_rows[i].exp_res);
    end

    // random phases, each under its own calibration
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_typical();
        1: write_calib('1, '1, '1, '1, '1);
        2: write_calib('0, '0, '0, '0, '0);
        5: begin
          write_typical();
          write_reg(hptc_pkg::REG_PRESS_HUM, {$urandom, $urandom});
          write_reg(hptc_pkg::REG_HUM, {$urandom, $urandom});
        end
        default: write_calib({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rp = $urandom;
        rt = $urandom;
        rh = $urandom;
        // some triples pinned to field extremes
        if ($urandom_range(4) == 0) begin
          if ($urandom_range(1)) rp = $urandom_range(1) ? '1 : '0;
          if ($urandom_range(1)) rt = $urandom_range(1) ? '1 : '0;
          if ($urandom_range(1)) rh = $urandom_range(1) ? '1 : '0;
        end
        send_triple(rp, rt, rh, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> humidity_pressure_temp_compensation_top.f
src/hptc_pkg.sv
src/hptc_mul64.sv
src/hptc_div.sv
src/humidity_pressure_temp_compensation_top.sv
dv/testbench.sv
